// File: hdl/assert_macros.svh
// Concurrent assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sspc_pkg.sv
package sspc_pkg;

    localparam int CRC_BYTES_DEF = 8;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [CFG_W-1:0] LOW_LIMIT_RST  = -16'sd960;
    localparam logic signed [CFG_W-1:0] HIGH_LIMIT_RST = 16'sd2080;
    localparam logic signed [CFG_W-1:0] POWER_ON_RST   = 16'sd1360;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_POWER_ON   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC      = 2'd1,
        ST_ABNORMAL = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] low_limit;
        logic signed [CFG_W-1:0] high_limit;
        logic signed [CFG_W-1:0] power_on_value;
    } limits_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] temperature;
        logic [7:0]         computed_crc;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/sspc_cfg_regs.sv
module sspc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspc_pkg::CFG_W-1:0]          cfg_data,
    output sspc_pkg::limits_t                   limits
);
    import sspc_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_LIMIT:  limits_next.low_limit      = cfg_data;
                REG_HIGH_LIMIT: limits_next.high_limit     = cfg_data;
                REG_POWER_ON:   limits_next.power_on_value = cfg_data;
                default:        limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.low_limit      <= LOW_LIMIT_RST;
            limits_reg.high_limit     <= HIGH_LIMIT_RST;
            limits_reg.power_on_value <= POWER_ON_RST;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

// File: hdl/sspc_in_reg.sv
module sspc_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      data_byte,
    input  logic            frame_start,
    input  logic            advance,
    output logic            in_stall,
    output logic            s1_valid,
    output sspc_pkg::item_t item
);
    import sspc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_stall = valid_reg && !advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (!valid_reg || advance)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload until the item moves on
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.data_byte   <= data_byte;
            item_reg.frame_start <= frame_start;
        end
    end

    assign s1_valid = valid_reg;
    assign item     = item_reg;

endmodule

// File: hdl/sspc_frame.sv
module sspc_frame #(
    parameter int CRC_BYTES = sspc_pkg::CRC_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  sspc_pkg::item_t     item,
    input  sspc_pkg::limits_t   limits,
    input  logic                out_free,
    output logic                advance,
    output logic                res_valid,
    output sspc_pkg::result_t   result
);
    import sspc_pkg::*;

    localparam int CNT_W = $clog2(CRC_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_CHECK = CNT_W'(CRC_BYTES);
    localparam logic [CNT_W-1:0] CNT_DONE  = CNT_W'(CRC_BYTES + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;
    logic [7:0]         low_reg;
    logic [7:0]         low_next;
    logic [7:0]         high_reg;
    logic [7:0]         high_next;
    logic [CNT_W-1:0]   cnt;
    logic [7:0]         crc;
    logic signed [15:0] temp;
    logic               abnormal;

    always_comb
    begin
        cnt        = item.frame_start ? '0 : count_reg;
        crc        = item.frame_start ? 8'h00 : crc_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        res_valid  = s1_valid && (cnt == CNT_CHECK);
        advance    = s1_valid && (!res_valid || out_free);
        temp       = {high_reg, low_reg};
        abnormal   = (temp == limits.power_on_value) || (temp < limits.low_limit)
                     || (temp > limits.high_limit);

        result.temperature  = temp;
        result.computed_crc = crc_reg;
        if (item.data_byte != crc_reg)
        begin
            result.status = ST_CRC;
        end
        else if (abnormal)
        begin
            result.status = ST_ABNORMAL;
        end
        else
        begin
            result.status = ST_OK;
        end

        if (advance)
        begin
            if (cnt < CNT_CHECK)
            begin
                crc_next   = crc8_byte(crc, item.data_byte);
                count_next = cnt + 1'b1;
                if (cnt == '0)
                begin
                    low_next = item.data_byte;
                end
                if (cnt == CNT_W'(1))
                begin
                    high_next = item.data_byte;
                end
            end
            else if (cnt == CNT_CHECK)
            begin
                count_next = CNT_DONE;
            end
            else
            begin
                // drop bytes past the check byte
                count_next = cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= 8'h00;
            low_reg   <= 8'h00;
            high_reg  <= 8'h00;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

endmodule

// File: hdl/sspc_out_reg.sv
module sspc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sspc_pkg::result_t   result,
    input  logic                out_stall,
    output logic                out_free,
    output logic                out_valid,
    output logic [1:0]          status,
    output logic signed [15:0]  temperature,
    output logic [7:0]          computed_crc
);
    import sspc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = result_reg.status;
    assign temperature  = result_reg.temperature;
    assign computed_crc = result_reg.computed_crc;

endmodule

// File: hdl/sensor_scratchpad_check_top.sv
// Path: an accepted item is held in the input register. The result of a check byte is
// then loaded into the output register, which drives out_valid, once that register is
// free; the result can be taken while out_stall is low. Throughput: one byte per cycle
// while in_stall is low, set by the combinational byte-wide CRC-8 update.
// Reset (rst_n, async, active low) clears the byte count, CRC, temperature bytes and valid
// flags, and loads the limit registers with their default values.
`include "assert_macros.svh"

module sensor_scratchpad_check_top #(
    parameter int CRC_BYTES = sspc_pkg::CRC_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sspc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            frame_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic signed [15:0]              temperature,
    output logic [7:0]                      computed_crc
);
    import sspc_pkg::*;

    limits_t limits;
    item_t   item;
    result_t result;
    logic    s1_valid;
    logic    advance;
    logic    res_valid;
    logic    res_load;
    logic    out_free;

    assign res_load = res_valid && advance;

    sspc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    sspc_in_reg u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .advance     (advance),
        .in_stall    (in_stall),
        .s1_valid    (s1_valid),
        .item        (item)
    );

    sspc_frame #(
        .CRC_BYTES (CRC_BYTES)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .item      (item),
        .limits    (limits),
        .out_free  (out_free),
        .advance   (advance),
        .res_valid (res_valid),
        .result    (result)
    );

    sspc_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .result       (result),
        .out_stall    (out_stall),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .status       (status),
        .temperature  (temperature),
        .computed_crc (computed_crc)
    );

    `ASSERT_IMPLY(a_load_free, res_load, out_free, "result loaded over a waiting result")
    `ASSERT_IMPLY(a_stall_held, in_stall, s1_valid, "stall raised with empty input stage")
    `ASSERT_NEXT(a_load_shows, res_load, out_valid, "loaded result not presented")

endmodule
